// File: design/ggx_pkg.sv
package ggx_pkg;

	localparam int COMP_W = 16;
	localparam int CFRAC  = COMP_W - 2;
	localparam int FRAC   = 16;
	localparam int UP     = (CFRAC <= FRAC) ? (FRAC - CFRAC) : 0;
	localparam int DN     = (CFRAC > FRAC) ? (CFRAC - FRAC) : 0;
	localparam int VEC_W  = FRAC + 2;

	localparam logic [31:0] SAT32    = 32'hFFFF_FFFF;
	localparam logic [17:0] PI_Q16   = 18'd205887;
	localparam logic [15:0] F0_DIEL  = 16'd2621;
	localparam logic [15:0] F0_SPAN  = 16'd62915;
	localparam logic [6:0]  DEN_EPS  = 7'd66;
	localparam logic [5:0]  SAFE_EPS = 6'd43;

	localparam int SQ_LAT  = 20;
	localparam int SQ_W    = 40;
	localparam int ROOT_W  = 20;
	localparam int DIV_N_W = 64;
	localparam int DIV_D_W = 48;
	localparam int DIV_LAT = 32;

	typedef struct packed {
		logic        gate;
		logic [37:0] dns;
		logic [19:0] nv;
		logic [19:0] nl;
		logic [21:0] gden_v;
		logic [21:0] gden_l;
		logic [15:0] a2;
		logic [15:0] f0;
		logic [16:0] b;
		logic [47:0] rgb;
	} sq_side_t;

	typedef struct packed {
		logic        gate;
		logic [19:0] nv;
		logic [19:0] nl;
		logic [15:0] a2;
		logic [15:0] f0;
		logic [16:0] b;
		logic [47:0] rgb;
	} nh_side_t;

	typedef struct packed {
		logic        dsat;
		logic        zero;
		logic        gclip;
		logic [16:0] f;
		logic [31:0] g;
		logic [26:0] den2;
		logic [19:0] nl;
		logic [47:0] rgb;
	} d_side_t;

	typedef struct packed {
		logic        ssat;
		logic        zero;
		logic        clip;
		logic [19:0] nl;
		logic [47:0] rgb;
	} s_side_t;

	// component i of a packed vector, rescaled to Q16, floor on right shift
	function automatic logic signed [VEC_W-1:0] unpack_comp(input logic [47:0] p, input int i);
		logic [71:0] ext;
		logic signed [COMP_W-1:0] raw;
		logic signed [COMP_W+UP-1:0] w;
		ext = {24'd0, p} >> (i * COMP_W);
		raw = signed'(ext[COMP_W-1:0]);
		w = raw;
		w = w <<< UP;
		w = w >>> DN;
		return VEC_W'(w);
	endfunction

endpackage

// File: design/ggx_specular_shader_core.sv
// GGX specular shader: Cook-Torrance term (GGX distribution, Schlick Fresnel,
// Smith-Schlick geometry) per shading sample, fixed point. One request is taken
// every cycle unless the output stalls; data runs through the square root
// (20 stages) and three 32-stage divider ranks in series (half vector,
// distribution, final quotient). A stall at the output holds the whole pipeline;
// the input is ready whenever the output register is empty or being taken.
module ggx_specular_shader_core import ggx_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// normal_vec, view_vec, light_vec, light_rgb, roughness, metallic
	input  logic [223:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// spec_red, spec_green, spec_blue
	output logic [95:0]  m_axis_tdata,
	// clipped
	output logic [0:0]   m_axis_tuser
);

	logic en;

	logic [47:0] in_n, in_v, in_l, in_rgb;
	logic [15:0] in_r, in_m;
	logic signed [VEC_W-1:0] nc [3];
	logic signed [VEC_W-1:0] vc [3];
	logic signed [VEC_W-1:0] lc [3];
	logic signed [VEC_W:0]   sc [3];

	assign in_n   = s_axis_tdata[47:0];
	assign in_v   = s_axis_tdata[95:48];
	assign in_l   = s_axis_tdata[143:96];
	assign in_rgb = s_axis_tdata[191:144];
	assign in_r   = s_axis_tdata[207:192];
	assign in_m   = s_axis_tdata[223:208];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nc[i] = unpack_comp(in_n, i);
			vc[i] = unpack_comp(in_v, i);
			lc[i] = unpack_comp(in_l, i);
			sc[i] = (VEC_W+1)'(vc[i]) + (VEC_W+1)'(lc[i]);
		end
	end

	// stage 1: products
	logic signed [2*VEC_W-1:0] pnv_s1 [3];
	logic signed [2*VEC_W-1:0] pnl_s1 [3];
	logic signed [2*VEC_W:0]   pns_s1 [3];
	logic signed [2*VEC_W+1:0] pss_s1 [3];
	logic [15:0] a_s1, m_s1;
	logic [33:0] rp2_s1;
	logic [47:0] rgb_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pnv_s1[i] <= nc[i] * vc[i];
				pnl_s1[i] <= nc[i] * lc[i];
				pns_s1[i] <= (2*VEC_W+1)'(nc[i]) * (2*VEC_W+1)'(sc[i]);
				pss_s1[i] <= (2*VEC_W+2)'(sc[i]) * (2*VEC_W+2)'(sc[i]);
			end
			a_s1   <= 16'((32'(in_r) * 32'(in_r)) >> 16);
			rp2_s1 <= 34'({1'b1, in_r}) * 34'({1'b1, in_r});
			m_s1   <= in_m;
			rgb_s1 <= in_rgb;
		end
	end

	// stage 2: dot products
	logic signed [2*VEC_W+1:0] dnv_c, dnl_c;
	logic signed [2*VEC_W+2:0] dns_c;
	logic signed [SQ_W-1:0]    len2_c;
	logic [19:0] nv_s2, nl_s2;
	logic signed [2*VEC_W+2:0] dns_s2;
	logic [SQ_W-1:0] len2_s2;
	logic [15:0] a2_s2, f0_s2;
	logic [14:0] k_s2;
	logic [47:0] rgb_s2;

	always_comb begin
		dnv_c  = '0;
		dnl_c  = '0;
		dns_c  = '0;
		len2_c = '0;
		for (int i = 0; i < 3; i++) begin
			dnv_c  = dnv_c + (2*VEC_W+2)'(pnv_s1[i]);
			dnl_c  = dnl_c + (2*VEC_W+2)'(pnl_s1[i]);
			dns_c  = dns_c + (2*VEC_W+3)'(pns_s1[i]);
			len2_c = len2_c + SQ_W'(pss_s1[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nv_s2   <= (!dnv_c[2*VEC_W+1] && dnv_c != 0) ? 20'(dnv_c >>> 16) : '0;
			nl_s2   <= (!dnl_c[2*VEC_W+1] && dnl_c != 0) ? 20'(dnl_c >>> 16) : '0;
			dns_s2  <= dns_c;
			len2_s2 <= len2_c;
			a2_s2   <= 16'((32'(a_s1) * 32'(a_s1)) >> 16);
			k_s2    <= 15'(rp2_s1 >> 19);
			f0_s2   <= 16'(32'(F0_DIEL) + ((32'(F0_SPAN) * 32'(m_s1)) >> 16));
			rgb_s2  <= rgb_s1;
		end
	end

	// stage 3: Smith denominators, Fresnel base
	logic [16:0] omk_c;
	sq_side_t    sq_in_s3;
	logic [SQ_W-1:0] len2_s3;

	assign omk_c = 17'h10000 - 17'(k_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			len2_s3         <= len2_s2;
			sq_in_s3.gate   <= (len2_s2 >= SQ_W'(SAFE_EPS)) && !dns_s2[2*VEC_W+2] && dns_s2 != 0;
			sq_in_s3.dns    <= dns_s2[37:0];
			sq_in_s3.nv     <= nv_s2;
			sq_in_s3.nl     <= nl_s2;
			sq_in_s3.gden_v <= 22'(((37'(nv_s2) * 37'(omk_c)) >> 16) + 37'(k_s2));
			sq_in_s3.gden_l <= 22'(((37'(nl_s2) * 37'(omk_c)) >> 16) + 37'(k_s2));
			sq_in_s3.a2     <= a2_s2;
			sq_in_s3.f0     <= f0_s2;
			sq_in_s3.b      <= 17'h10000 - ((nv_s2 > 20'h10000) ? 17'h10000 : 17'(nv_s2));
			sq_in_s3.rgb    <= rgb_s2;
		end
	end

	// square root of |V+L|^2
	logic [ROOT_W-1:0] root;
	sq_side_t sqd_s [SQ_LAT];
	sq_side_t sqo;

	ggx_isqrt u_isqrt (
		.clk  (clk),
		.en   (en),
		.x    (len2_s3),
		.root (root)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			sqd_s[0] <= sq_in_s3;
			for (int i = 1; i < SQ_LAT; i++) sqd_s[i] <= sqd_s[i-1];
		end
	end

	assign sqo = sqd_s[SQ_LAT-1];

	// NdotH and both Smith terms
	logic [DIV_LAT-1:0] quo_nh, quo_gv, quo_gl;
	nh_side_t n1d_s [DIV_LAT];
	nh_side_t o1;

	ggx_div u_div_nh (
		.clk (clk),
		.en  (en),
		.num (DIV_N_W'(sqo.dns)),
		.den (DIV_D_W'(root)),
		.quo (quo_nh)
	);

	ggx_div u_div_gv (
		.clk (clk),
		.en  (en),
		.num (DIV_N_W'({sqo.nv, 16'd0})),
		.den (DIV_D_W'(sqo.gden_v)),
		.quo (quo_gv)
	);

	ggx_div u_div_gl (
		.clk (clk),
		.en  (en),
		.num (DIV_N_W'({sqo.nl, 16'd0})),
		.den (DIV_D_W'(sqo.gden_l)),
		.quo (quo_gl)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			n1d_s[0] <= '{gate: sqo.gate, nv: sqo.nv, nl: sqo.nl, a2: sqo.a2, f0: sqo.f0,
				b: sqo.b, rgb: sqo.rgb};
			for (int i = 1; i < DIV_LAT; i++) n1d_s[i] <= n1d_s[i-1];
		end
	end

	assign o1 = n1d_s[DIV_LAT-1];

	// stage 4
	logic [19:0] nh_c;
	logic [63:0] gp_c;
	logic [23:0] nh2_s4;
	logic [31:0] g_s4;
	logic        gclip_s4;
	logic [16:0] p2_s4, b_s4;
	logic [26:0] den2_s4;
	logic [15:0] a2_s4, f0_s4;
	logic [19:0] nl_s4;
	logic [47:0] rgb_s4;

	assign nh_c = o1.gate ? quo_nh[19:0] : '0;
	assign gp_c = 64'(quo_gv) * 64'(quo_gl);

	always_ff @(posedge clk) begin
		if (en) begin
			nh2_s4   <= 24'((40'(nh_c) * 40'(nh_c)) >> 16);
			g_s4     <= (|gp_c[63:48]) ? SAT32 : gp_c[47:16];
			gclip_s4 <= |gp_c[63:48];
			p2_s4    <= 17'((34'(o1.b) * 34'(o1.b)) >> 16);
			den2_s4  <= 27'((40'(o1.nv) * 40'(o1.nl)) >> 14) + 27'(DEN_EPS);
			b_s4     <= o1.b;
			a2_s4    <= o1.a2;
			f0_s4    <= o1.f0;
			nl_s4    <= o1.nl;
			rgb_s4   <= o1.rgb;
		end
	end

	// stage 5: distribution denominator
	logic signed [24:0] nh2_sg;
	logic signed [17:0] am1_c;
	logic signed [42:0] dprod_c;
	logic signed [27:0] denom_s5;
	logic [16:0] p4_s5, b_s5;
	logic [31:0] g_s5;
	logic        gclip_s5;
	logic [26:0] den2_s5;
	logic [15:0] a2_s5, f0_s5;
	logic [19:0] nl_s5;
	logic [47:0] rgb_s5;

	assign nh2_sg  = signed'({1'b0, nh2_s4});
	assign am1_c   = signed'({2'b00, a2_s4}) - 18'sd65536;
	assign dprod_c = 43'(nh2_sg) * 43'(am1_c);

	always_ff @(posedge clk) begin
		if (en) begin
			denom_s5 <= 28'sd65536 + 28'(dprod_c >>> 16);
			p4_s5    <= 17'((34'(p2_s4) * 34'(p2_s4)) >> 16);
			b_s5     <= b_s4;
			g_s5     <= g_s4;
			gclip_s5 <= gclip_s4;
			den2_s5  <= den2_s4;
			a2_s5    <= a2_s4;
			f0_s5    <= f0_s4;
			nl_s5    <= nl_s4;
			rgb_s5   <= rgb_s4;
		end
	end

	// stage 6
	logic signed [55:0] dd_c;
	logic [45:0] dd_s6;
	logic        zero_s6;
	logic [16:0] p5_s6;
	logic [31:0] g_s6;
	logic        gclip_s6;
	logic [26:0] den2_s6;
	logic [15:0] a2_s6, f0_s6;
	logic [19:0] nl_s6;
	logic [47:0] rgb_s6;

	assign dd_c = 56'(denom_s5) * 56'(denom_s5);

	always_ff @(posedge clk) begin
		if (en) begin
			dd_s6    <= dd_c[45:0];
			zero_s6  <= denom_s5 == 0;
			p5_s6    <= 17'((34'(p4_s5) * 34'(b_s5)) >> 16);
			g_s6     <= g_s5;
			gclip_s6 <= gclip_s5;
			den2_s6  <= den2_s5;
			a2_s6    <= a2_s5;
			f0_s6    <= f0_s5;
			nl_s6    <= nl_s5;
			rgb_s6   <= rgb_s5;
		end
	end

	// stage 7: pi * denom^2 in two halves, Fresnel
	logic [40:0] pdlo_s7, pdhi_s7;
	logic [16:0] f_s7;
	logic        zero_s7;
	logic [31:0] g_s7;
	logic        gclip_s7;
	logic [26:0] den2_s7;
	logic [15:0] a2_s7;
	logic [19:0] nl_s7;
	logic [47:0] rgb_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			pdlo_s7  <= 41'(dd_s6[22:0]) * 41'(PI_Q16);
			pdhi_s7  <= 41'(dd_s6[45:23]) * 41'(PI_Q16);
			f_s7     <= 17'(f0_s6) + 17'((34'(17'h10000 - 17'(f0_s6)) * 34'(p5_s6)) >> 16);
			zero_s7  <= zero_s6;
			g_s7     <= g_s6;
			gclip_s7 <= gclip_s6;
			den2_s7  <= den2_s6;
			a2_s7    <= a2_s6;
			nl_s7    <= nl_s6;
			rgb_s7   <= rgb_s6;
		end
	end

	// stage 8
	logic [47:0] pd_s8;
	logic [16:0] f_s8;
	logic        zero_s8;
	logic [31:0] g_s8;
	logic        gclip_s8;
	logic [26:0] den2_s8;
	logic [15:0] a2_s8;
	logic [19:0] nl_s8;
	logic [47:0] rgb_s8;
	logic        dsat_c;

	always_ff @(posedge clk) begin
		if (en) begin
			pd_s8    <= 48'(((64'(pdhi_s7) << 23) + 64'(pdlo_s7)) >> 16);
			f_s8     <= f_s7;
			zero_s8  <= zero_s7;
			g_s8     <= g_s7;
			gclip_s8 <= gclip_s7;
			den2_s8  <= den2_s7;
			a2_s8    <= a2_s7;
			nl_s8    <= nl_s7;
			rgb_s8   <= rgb_s7;
		end
	end

	assign dsat_c = 48'(a2_s8) >= pd_s8;

	// distribution quotient
	logic [DIV_LAT-1:0] quo_d;
	d_side_t d2d_s [DIV_LAT];
	d_side_t o2;

	ggx_div u_div_d (
		.clk (clk),
		.en  (en),
		.num (DIV_N_W'({a2_s8, 32'd0})),
		.den (pd_s8),
		.quo (quo_d)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			d2d_s[0] <= '{dsat: dsat_c, zero: zero_s8, gclip: gclip_s8, f: f_s8, g: g_s8,
				den2: den2_s8, nl: nl_s8, rgb: rgb_s8};
			for (int i = 1; i < DIV_LAT; i++) d2d_s[i] <= d2d_s[i-1];
		end
	end

	assign o2 = d2d_s[DIV_LAT-1];

	// stage 9: D * F
	logic [31:0] d_c;
	logic [48:0] df_c;
	logic [31:0] df_s9, g_s9;
	logic        clip_s9, zero_s9;
	logic [26:0] den2_s9;
	logic [19:0] nl_s9;
	logic [47:0] rgb_s9;

	assign d_c  = o2.dsat ? SAT32 : quo_d;
	assign df_c = 49'(d_c) * 49'(o2.f);

	always_ff @(posedge clk) begin
		if (en) begin
			df_s9   <= df_c[48] ? SAT32 : df_c[47:16];
			clip_s9 <= o2.dsat | o2.gclip | df_c[48];
			g_s9    <= o2.g;
			zero_s9 <= o2.zero;
			den2_s9 <= o2.den2;
			nl_s9   <= o2.nl;
			rgb_s9  <= o2.rgb;
		end
	end

	// stage 10: * G
	logic [63:0] t_c;
	logic [31:0] t_s10;
	logic        clip_s10, zero_s10;
	logic [26:0] den2_s10;
	logic [19:0] nl_s10;
	logic [47:0] rgb_s10;
	logic        ssat_c;

	assign t_c = 64'(df_s9) * 64'(g_s9);

	always_ff @(posedge clk) begin
		if (en) begin
			t_s10    <= (|t_c[63:48]) ? SAT32 : t_c[47:16];
			clip_s10 <= clip_s9 | (|t_c[63:48]);
			zero_s10 <= zero_s9;
			den2_s10 <= den2_s9;
			nl_s10   <= nl_s9;
			rgb_s10  <= rgb_s9;
		end
	end

	assign ssat_c = 27'(t_s10[31:16]) >= den2_s10;

	// specular quotient
	logic [DIV_LAT-1:0] quo_sp;
	s_side_t s3d_s [DIV_LAT];
	s_side_t o3;

	ggx_div u_div_sp (
		.clk (clk),
		.en  (en),
		.num (DIV_N_W'({t_s10, 16'd0})),
		.den (DIV_D_W'(den2_s10)),
		.quo (quo_sp)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			s3d_s[0] <= '{ssat: ssat_c, zero: zero_s10, clip: clip_s10, nl: nl_s10,
				rgb: rgb_s10};
			for (int i = 1; i < DIV_LAT; i++) s3d_s[i] <= s3d_s[i-1];
		end
	end

	assign o3 = s3d_s[DIV_LAT-1];

	// stage 11: colour * spec
	logic [31:0] spec_c;
	logic [51:0] cs_c [3];
	logic [2:0]  cs_ov;
	logic [31:0] cs_s11 [3];
	logic        clip_s11, zero_s11;
	logic [19:0] nl_s11;

	assign spec_c = o3.ssat ? SAT32 : quo_sp;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cs_c[i]  = 52'({o3.rgb[16*i +: 16], 4'd0}) * 52'(spec_c);
			cs_ov[i] = |cs_c[i][51:48];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) cs_s11[i] <= cs_ov[i] ? SAT32 : cs_c[i][47:16];
			clip_s11 <= o3.clip | o3.ssat | (|cs_ov);
			zero_s11 <= o3.zero;
			nl_s11   <= o3.nl;
		end
	end

	// stage 12: * NdotL, output register
	logic [51:0] co_c [3];
	logic [2:0]  co_ov;
	logic [31:0] ch_s12 [3];
	logic        clip_s12;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			co_c[i]  = 52'(cs_s11[i]) * 52'(nl_s11);
			co_ov[i] = |co_c[i][51:48];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				ch_s12[i] <= (zero_s11 || co_ov[i]) ? SAT32 : co_c[i][47:16];
			clip_s12 <= zero_s11 | clip_s11 | (|co_ov);
		end
	end

	// valid bits
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic vld_s9, vld_s10, vld_s11, vld_s12;
	logic [SQ_LAT-1:0]  sqv_s;
	logic [DIV_LAT-1:0] n1v_s, d2v_s, s3v_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			sqv_s   <= '0;
			n1v_s   <= '0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			d2v_s   <= '0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			s3v_s   <= '0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
		end else if (en) begin
			vld_s1  <= s_axis_tvalid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			sqv_s   <= {sqv_s[SQ_LAT-2:0], vld_s3};
			n1v_s   <= {n1v_s[DIV_LAT-2:0], sqv_s[SQ_LAT-1]};
			vld_s4  <= n1v_s[DIV_LAT-1];
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			d2v_s   <= {d2v_s[DIV_LAT-2:0], vld_s8};
			vld_s9  <= d2v_s[DIV_LAT-1];
			vld_s10 <= vld_s9;
			s3v_s   <= {s3v_s[DIV_LAT-2:0], vld_s10};
			vld_s11 <= s3v_s[DIV_LAT-1];
			vld_s12 <= vld_s11;
		end
	end

	assign en            = !vld_s12 || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_s12;
	assign m_axis_tdata  = {ch_s12[2], ch_s12[1], ch_s12[0]};
	assign m_axis_tuser  = clip_s12;

	a_zero_denom: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s11 && en && zero_s11 |=> m_axis_tuser[0] && m_axis_tdata == {3{SAT32}})
		else $error("zero distribution denominator not saturated");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> vld_s1)
		else $error("accepted request lost at first stage");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s8 && !en |=> vld_s8 && $stable(pd_s8))
		else $error("stage 8 changed during stall");

endmodule

// File: design/ggx_isqrt.sv
module ggx_isqrt import ggx_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [SQ_W-1:0]   x,
	output logic [ROOT_W-1:0] root
);

	logic [SQ_W-1:0] x_s   [SQ_LAT];
	logic [SQ_W-1:0] res_s [SQ_LAT];

	for (genvar k = 0; k < SQ_LAT; k++) begin : g_stage
		localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQ_LAT - 1 - k));
		logic [SQ_W-1:0] x_in, res_in, trial;
		if (k == 0) begin : g_first
			assign x_in   = x;
			assign res_in = '0;
		end else begin : g_next
			assign x_in   = x_s[k-1];
			assign res_in = res_s[k-1];
		end
		assign trial = res_in + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (x_in >= trial) begin
					x_s[k]   <= x_in - trial;
					res_s[k] <= (res_in >> 1) + BIT;
				end else begin
					x_s[k]   <= x_in;
					res_s[k] <= res_in >> 1;
				end
			end
		end
	end

	assign root = ROOT_W'(res_s[SQ_LAT-1]);

endmodule

// File: design/ggx_div.sv
module ggx_div import ggx_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic [DIV_N_W-1:0] num,
	input  logic [DIV_D_W-1:0] den,
	output logic [DIV_LAT-1:0] quo
);

	// restoring long division, one quotient bit a stage; num < den << DIV_LAT
	logic [DIV_D_W-1:0] rem_s [DIV_LAT];
	logic [DIV_LAT-1:0] low_s [DIV_LAT];
	logic [DIV_LAT-1:0] quo_s [DIV_LAT];
	logic [DIV_D_W-1:0] den_s [DIV_LAT];

	for (genvar k = 0; k < DIV_LAT; k++) begin : g_stage
		logic [DIV_D_W-1:0] r_in, d_in;
		logic [DIV_LAT-1:0] l_in, q_in;
		logic [DIV_D_W:0]   t;
		logic               ge;
		if (k == 0) begin : g_first
			assign r_in = DIV_D_W'(num[DIV_N_W-1:DIV_LAT]);
			assign l_in = num[DIV_LAT-1:0];
			assign q_in = '0;
			assign d_in = den;
		end else begin : g_next
			assign r_in = rem_s[k-1];
			assign l_in = low_s[k-1];
			assign q_in = quo_s[k-1];
			assign d_in = den_s[k-1];
		end
		assign t  = {r_in, l_in[DIV_LAT-1]};
		assign ge = t >= {1'b0, d_in};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? DIV_D_W'(t - {1'b0, d_in}) : t[DIV_D_W-1:0];
				low_s[k] <= l_in << 1;
				quo_s[k] <= {q_in[DIV_LAT-2:0], ge};
				den_s[k] <= d_in;
			end
		end
	end

	assign quo = quo_s[DIV_LAT-1];

endmodule
